// ===== sv/plid_pkg.sv =====
// shared codes and controller/datapath interface types for the positional list
`timescale 1ns / 1ps
`default_nettype none
package plid_pkg;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 8;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 8;

    localparam logic [MODE_W-1:0] MODE_READ      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OVERWRITE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;         // capture the input item
        logic init_idx;     // start a shift sequence
        logic rd_en;        // issue a storage read
        logic step_write;   // write the fetched entry, move the index
        logic final_write;  // write the item value at its position
        logic finish;       // load the result register
    } plid_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic              proceed;     // request valid and not a clear
        logic [MODE_W-1:0] op;
        logic              shift_more;  // entries still to move
        logic              out_busy;    // result register cannot take a new item
    } plid_stat_t;

endpackage
`default_nettype wire

// ===== sv/plid_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module plid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/plid_ctrl.sv =====
// sequencing state machine for the positional list
`timescale 1ns / 1ps
`default_nettype none
module plid_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire plid_pkg::plid_stat_t stat,
    output plid_pkg::plid_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RD_WAIT,
        S_SH_CHK,
        S_SH_WR,
        S_FIN_WR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!stat.proceed)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (stat.op)
                        plid_pkg::MODE_READ:
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                        plid_pkg::MODE_OVERWRITE:
                        begin
                            state_next = S_FIN_WR;
                        end
                        plid_pkg::MODE_INSERT, plid_pkg::MODE_DELETE:
                        begin
                            cmd.init_idx = 1'b1;
                            state_next   = S_SH_CHK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                state_next = S_DONE;
            end
            S_SH_CHK:
            begin
                if (stat.shift_more)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SH_WR;
                end
                else if (stat.op == plid_pkg::MODE_INSERT)
                begin
                    state_next = S_FIN_WR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SH_WR:
            begin
                cmd.step_write = 1'b1;
                state_next     = S_SH_CHK;
            end
            S_FIN_WR:
            begin
                cmd.final_write = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/plid_dp.sv =====
// datapath: request registers, list storage, shift index, count and result register
`timescale 1ns / 1ps
`default_nettype none
module plid_dp #(
    parameter int DEPTH = 128
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [plid_pkg::MODE_W-1:0]         in_mode,
    input  wire logic [plid_pkg::POS_W-1:0]          in_position,
    input  wire logic signed [plid_pkg::VALUE_W-1:0] in_value,
    input  wire plid_pkg::plid_cmd_t                 cmd,
    output plid_pkg::plid_stat_t                     stat,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [plid_pkg::STAT_W-1:0]              out_status,
    output logic signed [plid_pkg::VALUE_W-1:0]      out_read_value,
    output logic [plid_pkg::COUNT_W-1:0]             out_count
);

    localparam int AW = $clog2(DEPTH);

    logic [plid_pkg::MODE_W-1:0]         mode_reg;
    logic [plid_pkg::POS_W-1:0]          pos_reg;
    logic signed [plid_pkg::VALUE_W-1:0] val_reg;
    logic [plid_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [plid_pkg::POS_W-1:0]          idx_reg;
    logic                                out_valid_reg;
    logic [plid_pkg::STAT_W-1:0]         status_reg;
    logic signed [plid_pkg::VALUE_W-1:0] rdval_reg;
    logic [plid_pkg::COUNT_W-1:0]        ocount_reg;

    logic [plid_pkg::STAT_W-1:0]         st_code;
    logic                                pos_in_list;
    logic                                pos_in_insert;
    logic                                full;
    logic [plid_pkg::POS_W-1:0]          pos_m1;
    logic [plid_pkg::POS_W-1:0]          rd_idx;
    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    logic [plid_pkg::VALUE_W-1:0]        ram_wdata;
    logic [plid_pkg::VALUE_W-1:0]        ram_rdata;

    assign pos_m1        = pos_reg - 8'd1;
    assign pos_in_list   = (pos_reg != '0) && (pos_reg <= count_reg);
    assign pos_in_insert = (pos_reg != '0) && ({1'b0, pos_reg} <= ({1'b0, count_reg} + 9'd1));
    assign full          = ({1'b0, count_reg} >= 9'(DEPTH));

    always_comb
    begin
        case (mode_reg)
            plid_pkg::MODE_READ, plid_pkg::MODE_OVERWRITE, plid_pkg::MODE_DELETE:
                st_code = pos_in_list ? plid_pkg::ST_OK : plid_pkg::ST_BADPOS;
            plid_pkg::MODE_INSERT:
                st_code = !pos_in_insert ? plid_pkg::ST_BADPOS
                        : (full ? plid_pkg::ST_FULL : plid_pkg::ST_OK);
            plid_pkg::MODE_CLEAR:
                st_code = plid_pkg::ST_OK;
            default:
                st_code = plid_pkg::ST_BADPOS;
        endcase
    end

    // insert walks down from the top, delete walks up from the hole
    always_comb
    begin
        stat.proceed  = (st_code == plid_pkg::ST_OK) && (mode_reg != plid_pkg::MODE_CLEAR);
        stat.op       = mode_reg;
        stat.out_busy = out_valid_reg && !out_ready;
        if (mode_reg == plid_pkg::MODE_INSERT)
        begin
            stat.shift_more = (idx_reg != pos_m1);
        end
        else
        begin
            stat.shift_more = ({1'b0, idx_reg} + 9'd1) < {1'b0, count_reg};
        end
    end

    always_comb
    begin
        case (mode_reg)
            plid_pkg::MODE_INSERT: rd_idx = idx_reg - 8'd1;
            plid_pkg::MODE_DELETE: rd_idx = idx_reg + 8'd1;
            default:               rd_idx = pos_m1;
        endcase
    end

    assign ram_we    = cmd.step_write || cmd.final_write;
    assign ram_waddr = cmd.final_write ? pos_m1[AW-1:0] : idx_reg[AW-1:0];
    assign ram_wdata = cmd.final_write ? val_reg : ram_rdata;

    plid_ram #(
        .WIDTH (plid_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (st_code == plid_pkg::ST_OK)
        begin
            case (mode_reg)
                plid_pkg::MODE_INSERT: count_next = count_reg + 8'd1;
                plid_pkg::MODE_DELETE: count_next = count_reg - 8'd1;
                plid_pkg::MODE_CLEAR:  count_next = '0;
                default:               count_next = count_reg;
            endcase
        end
    end

    // request, shift index and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            pos_reg  <= in_position;
            val_reg  <= in_value;
        end
        if (cmd.init_idx)
        begin
            idx_reg <= (mode_reg == plid_pkg::MODE_INSERT) ? count_reg : pos_m1;
        end
        else if (cmd.step_write)
        begin
            idx_reg <= rd_idx;
        end
        if (cmd.finish)
        begin
            status_reg <= st_code;
            rdval_reg  <= ((mode_reg == plid_pkg::MODE_READ) && (st_code == plid_pkg::ST_OK))
                        ? ram_rdata : '0;
            ocount_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = status_reg;
    assign out_read_value = rdval_reg;
    assign out_count      = ocount_reg;

endmodule
`default_nettype wire

// ===== sv/positional_list_insert_delete.sv =====
// top level of the positional list: controller, datapath and stream ports
//
// keeps an ordered list of up to DEPTH signed 32-bit values in a ram and
// answers one request item on the slave channel with one result item on
// the master channel. the request kind (read, insert, overwrite, delete,
// clear) rides in s_tuser, position and value in s_tdata. the result status
// rides in m_tuser, read value and new count in m_tdata.
//
// one item is worked at a time. insert and delete move one entry at a
// time through the single ram write port, reading it and writing it back
// one place over, up to DEPTH-1 entries per request. the next request can
// be accepted at the same edge at which the result can first be taken.
// s_tready is high only while the block is idle; the result register lets
// the next item be taken while a result still waits on m_tready. a stalled
// receiver holds the result and the block waits before loading the next
// one. reset clears the count and the result valid; the ram needs no
// clearing since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_insert_delete #(
    parameter int DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [7:0] position, [39:8] value
    input  wire logic [2:0]  s_tuser,   // [2:0] mode
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] read_value, [39:32] count
    output logic [1:0]       m_tuser    // [1:0] status
);

    plid_pkg::plid_cmd_t  cmd;
    plid_pkg::plid_stat_t stat;

    logic signed [plid_pkg::VALUE_W-1:0] read_value;
    logic [plid_pkg::COUNT_W-1:0]        count;

    // sequencer
    plid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage, checks and result register
    plid_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mode        (s_tuser),
        .in_position    (s_tdata[7:0]),
        .in_value       (s_tdata[39:8]),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (m_tuser),
        .out_read_value (read_value),
        .out_count      (count)
    );

    assign m_tdata = {count, read_value};

endmodule
`default_nettype wire

// ===== sv/plid_checker.sv =====
// port-level assertions for the positional list, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module plid_checker #(
    parameter int DEPTH = 128
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one request at a time: ready drops right after an accept
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after accept");

    // failed requests return a zero read value
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != 2'd0) |-> (m_tdata[31:0] == 32'd0))
        else $error("nonzero read value on failed request");

    // the count never passes the list depth
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[39:32]} <= 9'(DEPTH)))
        else $error("count beyond depth");

    // no unused status code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("bad status code");

endmodule

bind positional_list_insert_delete plid_checker #(
    .DEPTH (DEPTH)
) u_plid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
